/* design/cir_pkg.sv */
// Shared constants for the clock interpolator: register map, reset values and result codes.
package cir_pkg;

  localparam int unsigned RingDepthDefault = 16;

  localparam int unsigned StampW  = 48;
  localparam int unsigned BaseW   = 56;
  localparam int unsigned DivW    = 8;
  localparam int unsigned CapW    = 24;
  localparam int unsigned TimeW   = 57;
  localparam int unsigned SrcW    = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ThrW    = StampW + 1;

  localparam logic [CfgIdxW-1:0] CFG_BASE_TIME = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_DIV  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_CAP  = 2'd2;

  localparam logic [DivW-1:0] SyncDivReset = 8'd10;
  localparam logic [CapW-1:0] SyncCapReset = 24'd1000000;

  localparam logic [SrcW-1:0] SRC_SYNC = 2'd0;
  localparam logic [SrcW-1:0] SRC_PRED = 2'd1;
  localparam logic [SrcW-1:0] SRC_MEAS = 2'd2;

endpackage

/* design/clock_interpolator_regression_top.sv */
// Clock interpolator with a sample ring in memory and a least-squares line fit.
//
//  channel  direction  handshake                payload
//  input    in         in_valid_i / in_stall_o  cycle_stamp_i, wall_time_i
//  output   out        out_valid_o / out_stall_i time_us_o, source_o
//  config   in         cfg_we_i                 cfg_idx_i, cfg_data_i
//
// A non-sync request gets its wall time, or a fit prediction when the ring is full.
// A sync runs the one-bit-per-cycle divider up to three times; every filled ring entry
// is read once and multiplied twice by the 16-bit-digit multiplier. One request is in
// work at a time.
// Reset clears the fit and counters and sets the registers to their reset values; the ring memory is not cleared.
// A result waits in the output register under stall while the next request is taken.
module clock_interpolator_regression_top #(
  parameter int unsigned RING_DEPTH = cir_pkg::RingDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cir_pkg::StampW-1:0]    cycle_stamp_i,
  input  logic [cir_pkg::StampW-1:0]    wall_time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cir_pkg::TimeW-1:0]     time_us_o,
  output logic [cir_pkg::SrcW-1:0]      source_o,
  input  logic                          cfg_we_i,
  input  logic [cir_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cir_pkg::BaseW-1:0]     cfg_data_i
);
  import cir_pkg::*;

  localparam int unsigned CW   = $clog2(RING_DEPTH + 1);
  localparam int unsigned SW   = $clog2(RING_DEPTH);
  localparam int unsigned SXW  = StampW + CW;
  localparam int unsigned SQW  = 2 * StampW + CW;
  localparam int unsigned DENW = 2 * StampW + 2 * CW;
  localparam int unsigned DVW  = DENW + 64;
  localparam int unsigned AD   = (SQW + 15) / 16;
  localparam int unsigned AR   = AD * 16;
  localparam int unsigned PW   = AR + 64;
  localparam int unsigned XD   = (SXW + 15) / 16;
  localparam int unsigned SD   = (StampW + 15) / 16;
  localparam int unsigned MCW  = $clog2(AD + 1);
  localparam int unsigned VW   = 114;

  typedef enum logic [4:0] {
    S_IDLE, S_DIV, S_MUL, S_THR, S_RD, S_ACC, S_XX, S_XY,
    S_DEN0, S_DEN1, S_DEN2, S_NUM1, S_NUM2, S_SLOPE, S_ICPT, S_ICPT2,
    S_PRED, S_OUT
  } state_e;

  state_e state_q, ret_q;

  logic [BaseW-1:0]   base_q;
  logic [DivW-1:0]    div_q;
  logic [CapW-1:0]    cap_q;
  logic [StampW-1:0]  stamp_q, wall_q;
  logic [ThrW-1:0]    thr_q;
  logic [63:0]        slope_q, icpt_q;
  logic [CW-1:0]      fill_q, idx_q;
  logic [SW-1:0]      slot_q;
  logic [SXW-1:0]     sx_q, sy_q;
  logic [SQW-1:0]     sxx_q, sxy_q;
  logic [DENW-1:0]    tmp_q;
  logic [DENW:0]      den_q, num_q;
  logic [2*StampW-1:0] rd_q;
  logic [2*StampW-1:0] smp_mem [RING_DEPTH];

  logic [AR-1:0]      mul_a_q;
  logic [63:0]        mul_b_q;
  logic [PW-1:0]      mul_acc_q;
  logic [MCW-1:0]     mul_cnt_q;

  logic [DVW-1:0]     dv_rem_q, dv_dsh_q;
  logic [64:0]        dv_quo_q;
  logic [6:0]         dv_cnt_q;
  logic               dv_neg_q;

  logic [BaseW-1:0]   res_q;
  logic [SrcW-1:0]    src_q;
  logic               out_valid_q;
  logic [TimeW-1:0]   out_time_q;
  logic [SrcW-1:0]    out_src_q;

  logic               in_acc, is_sync, ring_full, dv_ge, out_free, out_load;
  logic [79:0]        mul_pp;
  logic [PW-1:0]      mul_acc_nx;
  logic [63:0]        dv_res;
  logic [ThrW-1:0]    thr_a, thr_b;
  logic [DENW-1:0]    num_mag;
  logic [DVW:0]       t_val;
  logic [DVW-1:0]     t_mag;
  logic [VW-1:0]      v_ic, v_p, v_val;
  logic [BaseW-1:0]   pred;
  logic [StampW-1:0]  rd_x, rd_y;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_sync     = {1'b0, cycle_stamp_i} > thr_q;
  assign ring_full   = (fill_q == CW'(RING_DEPTH));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == S_OUT) && (ret_q != S_OUT) && out_free;
  assign out_valid_o = out_valid_q;
  assign time_us_o   = out_time_q;
  assign source_o    = out_src_q;
  assign rd_x        = rd_q[2*StampW-1:StampW];
  assign rd_y        = rd_q[StampW-1:0];

  // Multiplier: most significant 16-bit digit of A first, times all of B.
  assign mul_pp     = mul_a_q[AR-1 -: 16] * mul_b_q;
  assign mul_acc_nx = (mul_acc_q << 16) + PW'(mul_pp);

  assign dv_ge = (dv_rem_q >= dv_dsh_q);

  always_comb begin
    if (dv_neg_q) begin
      dv_res = (|dv_quo_q[64:63]) ? 64'h8000_0000_0000_0000 : (~dv_quo_q[63:0] + 64'd1);
    end else begin
      dv_res = (|dv_quo_q[64:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : dv_quo_q[63:0];
    end
  end

  assign thr_a = ThrW'(stamp_q) + ThrW'(dv_quo_q[StampW-1:0]);
  assign thr_b = ThrW'(stamp_q) + ThrW'(cap_q);

  assign num_mag = num_q[DENW] ? DENW'(~num_q + 1'b1) : num_q[DENW-1:0];

  // Intercept numerator: sum of times scaled to Q.32 minus slope times sum of stamps.
  always_comb begin
    if (slope_q[63]) begin
      t_val = (DVW + 1)'(DVW'(sy_q) << 32) + (DVW + 1)'(DVW'(mul_acc_q));
    end else begin
      t_val = (DVW + 1)'(DVW'(sy_q) << 32) - (DVW + 1)'(DVW'(mul_acc_q));
    end
    t_mag = t_val[DVW] ? DVW'(~t_val + 1'b1) : t_val[DVW-1:0];
  end

  always_comb begin
    v_ic  = {{(VW - 80){icpt_q[63]}}, icpt_q, 16'b0};
    v_p   = VW'(mul_acc_q);
    v_val = slope_q[63] ? (v_ic - v_p) : (v_ic + v_p);
    if (v_val[VW-1]) begin
      pred = '0;
    end else if (|v_val[VW-2:88]) begin
      pred = {BaseW{1'b1}};
    end else begin
      pred = v_val[87:32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_sync) begin
      smp_mem[slot_q] <= {cycle_stamp_i, wall_time_i};
    end
    rd_q <= smp_mem[idx_q[SW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      base_q      <= '0;
      div_q       <= SyncDivReset;
      cap_q       <= SyncCapReset;
      stamp_q     <= '0;
      wall_q      <= '0;
      thr_q       <= ThrW'(1);
      slope_q     <= '0;
      icpt_q      <= '0;
      fill_q      <= '0;
      idx_q       <= '0;
      slot_q      <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      sxx_q       <= '0;
      sxy_q       <= '0;
      tmp_q       <= '0;
      den_q       <= '0;
      num_q       <= '0;
      mul_a_q     <= '0;
      mul_b_q     <= '0;
      mul_acc_q   <= '0;
      mul_cnt_q   <= '0;
      dv_rem_q    <= '0;
      dv_dsh_q    <= '0;
      dv_quo_q    <= '0;
      dv_cnt_q    <= '0;
      dv_neg_q    <= 1'b0;
      res_q       <= '0;
      src_q       <= SRC_SYNC;
      out_valid_q <= 1'b0;
      out_time_q  <= '0;
      out_src_q   <= SRC_SYNC;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BASE_TIME: base_q <= cfg_data_i;
          CFG_SYNC_DIV:  div_q  <= cfg_data_i[DivW-1:0];
          CFG_SYNC_CAP:  cap_q  <= cfg_data_i[CapW-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            stamp_q <= cycle_stamp_i;
            wall_q  <= wall_time_i;
            if (is_sync) begin
              slot_q <= (slot_q == SW'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
              if (!ring_full) begin
                fill_q <= fill_q + 1'b1;
              end
              // Threshold step: stamp over the divisor, a zero divisor counts as one.
              dv_rem_q <= DVW'(cycle_stamp_i);
              dv_dsh_q <= DVW'((div_q == '0) ? DivW'(1) : div_q) << 64;
              dv_quo_q <= '0;
              dv_cnt_q <= 7'd64;
              dv_neg_q <= 1'b0;
              ret_q    <= S_THR;
              state_q  <= S_DIV;
            end else if (ring_full) begin
              mul_a_q   <= AR'(cycle_stamp_i) << (AR - 16 * SD);
              mul_b_q   <= slope_q[63] ? (~slope_q + 64'd1) : slope_q;
              mul_acc_q <= '0;
              mul_cnt_q <= MCW'(SD);
              ret_q     <= S_PRED;
              state_q   <= S_MUL;
            end else begin
              res_q   <= BaseW'(wall_time_i);
              src_q   <= SRC_MEAS;
              state_q <= S_OUT;
            end
          end
        end

        S_DIV: begin
          dv_rem_q <= dv_ge ? (dv_rem_q - dv_dsh_q) : dv_rem_q;
          dv_quo_q <= {dv_quo_q[63:0], dv_ge};
          dv_dsh_q <= dv_dsh_q >> 1;
          dv_cnt_q <= dv_cnt_q - 7'd1;
          if (dv_cnt_q == '0) begin
            state_q <= ret_q;
          end
        end

        S_MUL: begin
          mul_acc_q <= mul_acc_nx;
          mul_a_q   <= mul_a_q << 16;
          mul_cnt_q <= mul_cnt_q - 1'b1;
          if (mul_cnt_q == MCW'(1)) begin
            state_q <= ret_q;
          end
        end

        S_THR: begin
          thr_q   <= (thr_a < thr_b) ? thr_a : thr_b;
          sx_q    <= '0;
          sy_q    <= '0;
          sxx_q   <= '0;
          sxy_q   <= '0;
          idx_q   <= '0;
          state_q <= S_RD;
        end

        S_RD: begin
          state_q <= S_ACC;
        end

        S_ACC: begin
          sx_q      <= sx_q + SXW'(rd_x);
          sy_q      <= sy_q + SXW'(rd_y);
          mul_a_q   <= AR'(rd_x) << (AR - 16 * SD);
          mul_b_q   <= 64'(rd_x);
          mul_acc_q <= '0;
          mul_cnt_q <= MCW'(SD);
          ret_q     <= S_XX;
          state_q   <= S_MUL;
        end

        S_XX: begin
          sxx_q     <= sxx_q + SQW'(mul_acc_q);
          mul_a_q   <= AR'(rd_x) << (AR - 16 * SD);
          mul_b_q   <= 64'(rd_y);
          mul_acc_q <= '0;
          mul_cnt_q <= MCW'(SD);
          ret_q     <= S_XY;
          state_q   <= S_MUL;
        end

        S_XY: begin
          sxy_q <= sxy_q + SQW'(mul_acc_q);
          idx_q <= idx_q + 1'b1;
          if (idx_q + 1'b1 == fill_q) begin
            state_q <= S_DEN0;
          end else begin
            state_q <= S_RD;
          end
        end

        S_DEN0: begin
          mul_a_q   <= AR'(sxx_q);
          mul_b_q   <= 64'(fill_q);
          mul_acc_q <= '0;
          mul_cnt_q <= MCW'(AD);
          ret_q     <= S_DEN1;
          state_q   <= S_MUL;
        end

        S_DEN1: begin
          tmp_q     <= DENW'(mul_acc_q);
          mul_a_q   <= AR'(sx_q) << (AR - 16 * XD);
          mul_b_q   <= 64'(sx_q);
          mul_acc_q <= '0;
          mul_cnt_q <= MCW'(XD);
          ret_q     <= S_DEN2;
          state_q   <= S_MUL;
        end

        S_DEN2: begin
          den_q     <= (DENW + 1)'(tmp_q) - (DENW + 1)'(DENW'(mul_acc_q));
          mul_a_q   <= AR'(sxy_q);
          mul_b_q   <= 64'(fill_q);
          mul_acc_q <= '0;
          mul_cnt_q <= MCW'(AD);
          ret_q     <= S_NUM1;
          state_q   <= S_MUL;
        end

        S_NUM1: begin
          tmp_q     <= DENW'(mul_acc_q);
          mul_a_q   <= AR'(sx_q) << (AR - 16 * XD);
          mul_b_q   <= 64'(sy_q);
          mul_acc_q <= '0;
          mul_cnt_q <= MCW'(XD);
          ret_q     <= S_NUM2;
          state_q   <= S_MUL;
        end

        S_NUM2: begin
          num_q <= (DENW + 1)'(tmp_q) - (DENW + 1)'(DENW'(mul_acc_q));
          // A flat or degenerate sample set leaves the previous fit in place.
          if (den_q[DENW] || (den_q == '0)) begin
            res_q   <= BaseW'(wall_q);
            src_q   <= SRC_SYNC;
            state_q <= S_OUT;
          end else begin
            state_q <= S_SLOPE;
          end
        end

        S_SLOPE: begin
          dv_rem_q <= DVW'(num_mag) << 32;
          dv_dsh_q <= DVW'(den_q[DENW-1:0]) << 64;
          dv_quo_q <= '0;
          dv_cnt_q <= 7'd64;
          dv_neg_q <= num_q[DENW];
          ret_q    <= S_ICPT;
          state_q  <= S_DIV;
        end

        S_ICPT: begin
          slope_q   <= dv_res;
          mul_a_q   <= AR'(sx_q) << (AR - 16 * XD);
          mul_b_q   <= dv_res[63] ? (~dv_res + 64'd1) : dv_res;
          mul_acc_q <= '0;
          mul_cnt_q <= MCW'(XD);
          ret_q     <= S_ICPT2;
          state_q   <= S_MUL;
        end

        S_ICPT2: begin
          if (ret_q == S_ICPT2) begin
            dv_rem_q <= t_mag;
            dv_dsh_q <= DVW'(fill_q) << (16 + 64);
            dv_quo_q <= '0;
            dv_cnt_q <= 7'd64;
            dv_neg_q <= t_val[DVW];
            ret_q    <= S_OUT;
            state_q  <= S_DIV;
          end
        end

        S_PRED: begin
          res_q   <= pred;
          src_q   <= SRC_PRED;
          state_q <= S_OUT;
        end

        S_OUT: begin
          // The intercept division returns here; its quotient is stored first.
          if (ret_q == S_OUT) begin
            icpt_q  <= dv_res;
            res_q   <= BaseW'(wall_q);
            src_q   <= SRC_SYNC;
            ret_q   <= S_IDLE;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            out_time_q  <= TimeW'(base_q) + TimeW'(res_q);
            out_src_q   <= src_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
